// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int DATA_W = 16;

  localparam logic [7:0] CH_FG_ESCAPE = 8'h24;  // '$'
  localparam logic [7:0] CH_BG_ESCAPE = 8'h26;  // '&'
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [3:0] FG_RESET   = 4'h7;
  localparam logic [3:0] BG_RESET   = 4'h0;

  typedef enum logic [1:0] {
    REQ_PLAIN  = 2'd0,
    REQ_FORMAT = 2'd1,
    REQ_ATTR   = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       first_of_string;
    logic       last_of_string;
  } tcw_item_t;

  typedef struct packed {
    logic              cell_write;
    logic [IDX_W-1:0]  cell_index;
    logic [DATA_W-1:0] cell_data;
    logic              cursor_update;
    logic [IDX_W-1:0]  cursor_index;
  } tcw_result_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [7:0]       attr;
    logic [3:0]       fg;
    logic [3:0]       bg;
    logic             esc_pending;
    logic             esc_is_bg;
  } tcw_state_t;

endpackage

// File: sv/tcw_if.sv
// Valid/ready channel interfaces for console items and cell results.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic [7:0] attribute;
  logic       first_of_string;
  logic       last_of_string;

  modport source (output valid, req_type, char_code, attribute, first_of_string,
                  last_of_string, input ready);
  modport sink   (input valid, req_type, char_code, attribute, first_of_string,
                  last_of_string, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic        cell_write;
  logic [10:0] cell_index;
  logic [15:0] cell_data;
  logic        cursor_update;
  logic [10:0] cursor_index;

  modport source (output valid, cell_write, cell_index, cell_data, cursor_update,
                  cursor_index, input ready);
  modport sink   (input valid, cell_write, cell_index, cell_data, cursor_update,
                  cursor_index, output ready);
endinterface

// File: sv/tcw_step.sv
// Next-state and result logic for one console item.
module tcw_step
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  tcw_state_t  state,
  input  tcw_item_t   item,
  output tcw_state_t  state_next,
  output tcw_result_t result
);

  localparam int LIN_W = COL_W + ROW_W + 1;

  function automatic logic [IDX_W-1:0] lin_index(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    logic [LIN_W-1:0] sum;
    sum = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_after(input logic [ROW_W-1:0] r);
    logic [ROW_W:0] inc;
    inc = {1'b0, r} + 1'b1;
    return (inc >= (ROW_W+1)'(ROWS)) ? '0 : inc[ROW_W-1:0];
  endfunction

  logic           put;
  logic           hex_ok;
  logic [3:0]     hex_val;
  logic [COL_W:0] col_inc;
  logic [7:0]     ch;

  assign ch = item.char_code;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (ch inside {[8'h30:8'h39]}) begin
      hex_val = 4'(ch - 8'h30);
    end else if (ch inside {[8'h41:8'h46]}) begin
      hex_val = 4'(ch - 8'h41 + 8'd10);
    end else if (ch inside {[8'h61:8'h66]}) begin
      hex_val = 4'(ch - 8'h61 + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    state_next            = state;
    put                   = 1'b0;
    result.cell_write     = 1'b0;
    result.cell_index     = '0;
    result.cell_data      = '0;
    result.cursor_update  = 1'b0;
    col_inc               = '0;

    case (req_type_t'(item.req_type))
      REQ_PLAIN: begin
        state_next.esc_pending = 1'b0;
        put                    = 1'b1;
        result.cursor_update   = item.last_of_string;
      end
      REQ_FORMAT: begin
        // A first item restarts the string with the stored colors.
        if (item.first_of_string) begin
          state_next.esc_pending = 1'b0;
          state_next.attr        = {state.bg, state.fg};
        end
        if (state_next.esc_pending) begin
          state_next.esc_pending = 1'b0;
          if (hex_ok) begin
            if (state.esc_is_bg) begin
              state_next.bg   = hex_val;
              state_next.attr = {hex_val, state.fg};
            end else begin
              state_next.fg   = hex_val;
              state_next.attr = {state.bg, hex_val};
            end
          end
        end else if ((ch == CH_FG_ESCAPE || ch == CH_BG_ESCAPE) && !item.last_of_string) begin
          state_next.esc_pending = 1'b1;
          state_next.esc_is_bg   = (ch == CH_BG_ESCAPE);
        end else begin
          put = 1'b1;
        end
        result.cursor_update = item.last_of_string;
      end
      REQ_ATTR: begin
        state_next.esc_pending = 1'b0;
        state_next.attr        = item.attribute;
      end
      default: begin
      end
    endcase

    if (put) begin
      case (ch)
        CH_NEWLINE: begin
          state_next.column = '0;
          state_next.row    = row_after(state.row);
        end
        CH_RETURN: begin
          state_next.column = '0;
        end
        CH_BACKSPACE: begin
          if (state.column != '0) begin
            state_next.column = state.column - 1'b1;
          end
          result.cell_write = 1'b1;
          result.cell_index = lin_index(state.row, state_next.column);
          result.cell_data  = {state_next.attr, CH_SPACE};
        end
        default: begin
          result.cell_write = 1'b1;
          result.cell_index = lin_index(state.row, state.column);
          result.cell_data  = {state_next.attr, ch};
          col_inc           = {1'b0, state.column} + 1'b1;
          if (col_inc >= (COL_W+1)'(COLUMNS)) begin
            state_next.column = '0;
            state_next.row    = row_after(state.row);
          end else begin
            state_next.column = col_inc[COL_W-1:0];
          end
        end
      endcase
    end

    result.cursor_index = lin_index(state_next.row, state_next.column);
  end

endmodule

// File: sv/text_console_writer.sv
// Top level of the text console writer: cursor state and the result register.
//
// The text console writer turns a stream of characters into screen cell
// writes for a COLUMNS x ROWS text display. Every accepted item produces
// exactly one result transfer through the output register, carrying an
// optional cell write ({attribute, character} at row*COLUMNS+column) and the
// cursor position after the item, with cursor_update raised on the last item
// of a plain or formatted string. The block accepts one item per clock cycle:
// the complete cursor, attribute and color-escape update for an item is a
// single combinational pass from the current state to the next, so the only
// limit on throughput is the output register. That register is a single
// stage; while it holds a result that the sink has not taken, a new item is
// accepted only in a cycle in which the held result leaves. Index values are
// reduced to 11 bits.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  tcw_in_if.sink         in_ch,
  tcw_out_if.source      out_ch
);

  tcw_state_t  state;
  tcw_state_t  state_next;
  tcw_item_t   item;
  tcw_result_t step_result;
  tcw_result_t result;
  logic        out_valid;
  logic        in_accept;

  // The input side stays open whenever the result register is empty or is
  // being emptied by a transfer in this same cycle.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign item.req_type        = in_ch.req_type;
  assign item.char_code       = in_ch.char_code;
  assign item.attribute       = in_ch.attribute;
  assign item.first_of_string = in_ch.first_of_string;
  assign item.last_of_string  = in_ch.last_of_string;

  tcw_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (step_result)
  );

  // Cursor, attribute and escape state advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.column      <= '0;
      state.row         <= '0;
      state.attr        <= ATTR_RESET;
      state.fg          <= FG_RESET;
      state.bg          <= BG_RESET;
      state.esc_pending <= 1'b0;
      state.esc_is_bg   <= 1'b0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The result payload needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= step_result;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.cell_write    = result.cell_write;
  assign out_ch.cell_index    = result.cell_index;
  assign out_ch.cell_data     = result.cell_data;
  assign out_ch.cursor_update = result.cursor_update;
  assign out_ch.cursor_index  = result.cursor_index;

endmodule

// File: sv/tcw_checker.sv
// Port-level assertions for the text console writer and their bind.
module tcw_port_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              cell_write,
  input logic [IDX_W-1:0]  cell_index,
  input logic [DATA_W-1:0] cell_data,
  input logic [IDX_W-1:0]  cursor_index
);

  localparam int  CELLS      = COLUMNS * ROWS;
  localparam bit  IDX_BOUNDS = (CELLS <= (1 << IDX_W));

  // Every accepted item is followed by a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A result without a cell write carries a zero index and zero data.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cell_write) |-> (cell_index == '0 && cell_data == '0))
    else $error("cell fields nonzero without a cell write");

  // Line control characters move the cursor and never reach the screen.
  a_no_ctrl_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cell_write) |->
      (cell_data[7:0] != CH_NEWLINE && cell_data[7:0] != CH_RETURN &&
       cell_data[7:0] != CH_BACKSPACE))
    else $error("line control character written to a cell");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && IDX_BOUNDS) |-> ({1'b0, cursor_index} < (IDX_W+1)'(CELLS)))
    else $error("cursor index beyond the screen");

endmodule

bind text_console_writer tcw_port_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .cell_write   (out_ch.cell_write),
  .cell_index   (out_ch.cell_index),
  .cell_data    (out_ch.cell_data),
  .cursor_index (out_ch.cursor_index)
);
